// ----- design/panel_link_serial_port_top_defines.svh -----
// assertion macros for the panel link serial port block
`ifndef PANEL_LINK_SERIAL_PORT_TOP_DEFINES_SVH
`define PANEL_LINK_SERIAL_PORT_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define PLSP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// condition must never be seen outside reset
`define PLSP_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define PLSP_ASSERT(lbl, prop, msg)
`define PLSP_NEVER(lbl, cond, msg)
`endif

`endif

// ----- design/plsp_pkg.sv -----
// shared constants, types and helpers of the panel link serial port
package plsp_pkg;

	// default sizing
	localparam int FRAME_BYTES_DEF = 40;
	localparam int REG_WORDS_DEF   = 1024;

	// register word indexes
	localparam logic [9:0] W_TXDATA   = 10'd3;
	localparam logic [9:0] W_STATUS   = 10'd4;
	localparam logic [9:0] W_RXDATA   = 10'd5;
	localparam logic [9:0] W_FIFOCTL  = 10'd6;
	localparam logic [9:0] W_FILL     = 10'd7;
	localparam logic [9:0] W_LINESTAT = 10'd9;

	// status bits
	localparam logic [15:0] ST_RDF   = 16'h0002;
	localparam logic [15:0] ST_TDFE  = 16'h0020;
	localparam logic [15:0] ST_TEND  = 16'h0040;
	localparam logic [15:0] ST_HW    = 16'h009F;
	localparam logic [15:0] ST_RESET = ST_TEND | ST_TDFE;

	// fifo control bits
	localparam logic [15:0] FC_RXRST = 16'h0002;
	localparam logic [15:0] FC_TXRST = 16'h0004;

	// fill count read mask
	localparam logic [15:0] FILL_MASK = 16'h007F;

	// reply framing
	localparam logic [7:0] SYNC_BYTE = 8'h8F;

	// report bytes that come out of reset at mid level
	localparam logic [5:0] RPT_MID_IDX_A = 6'd4;
	localparam logic [5:0] RPT_MID_IDX_B = 6'd6;
	localparam logic [7:0] RPT_MID_LEVEL = 8'h80;

	// request operation codes
	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_LOAD  = 2'd2
	} plsp_op_t;

	// control sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_COPY,
		ST_CSUM,
		ST_SYNC
	} plsp_state_t;

	// report byte value before the peer has loaded it
	function automatic logic [7:0] rpt_reset_byte(input logic [5:0] idx);
		logic [7:0] val;
		val = 8'h00;
		if (idx == RPT_MID_IDX_A || idx == RPT_MID_IDX_B) begin
			val = RPT_MID_LEVEL;
		end
		return val;
	endfunction

endpackage

// ----- design/panel_link_serial_port_top.sv -----
// top level of the panel link serial port register block
//
//   channel   direction   handshake           payload
//   request   in          in_valid/in_stall   op, reg_word, wdata, report_index, report_byte
//   result    out         out_valid/out_stall rdata, frame_done, starved
//
// A request is handled in a read step, which reads the register store and reply queue,
// then an update step, which updates them and loads the result register. A transmit
// write that completes a frame then walks the report store (one byte a cycle through its
// read port) and adds the checksum and sync writes into the reply queue. After reset the
// register store is cleared one word a cycle, with in_stall high. A stalled result holds
// only the final update step of the next request.
`include "panel_link_serial_port_top_defines.svh"

module panel_link_serial_port_top #(
	parameter int FRAME_BYTES = plsp_pkg::FRAME_BYTES_DEF,
	parameter int REG_WORDS   = plsp_pkg::REG_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [9:0]  reg_word,
	input  logic [15:0] wdata,
	input  logic [5:0]  report_index,
	input  logic [7:0]  report_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] rdata,
	output logic        frame_done,
	output logic        starved
);

	localparam int PL  = FRAME_BYTES - 2;
	localparam int RAW = (PL > 1) ? $clog2(PL) : 1;
	localparam int PW  = $clog2(PL + 1);
	localparam int QAW = $clog2(FRAME_BYTES);
	localparam int CW  = $clog2(FRAME_BYTES + 1);
	localparam int AW  = $clog2(REG_WORDS);

	// sequencer and request registers
	plsp_pkg::plsp_state_t state_q, state_d;
	plsp_pkg::plsp_op_t    op_q;
	logic [AW-1:0]  clr_q;
	logic [9:0]     word_q;
	logic [15:0]    wdata_q;
	logic [5:0]     ridx_q;
	logic [7:0]     rbyte_q;

	// queue and frame counters
	logic [QAW-1:0] head_q, head_d;
	logic [CW-1:0]  count_q, count_d;
	logic [CW-1:0]  tx_q, tx_d, tx_inc;
	logic [PL-1:0]  rpt_vld_q;

	// copy walk
	logic [PW-1:0]  cp_rd_q;
	logic           cp_vld_s1;
	logic [RAW-1:0] cp_idx_s1;
	logic [7:0]     acc_q, acc_next, cp_byte;
	logic [8:0]     acc_sum;

	// result register
	logic           out_valid_q, done_q, starved_q;
	logic [15:0]    rdata_q;

	// strobes and result values
	logic           accept, out_load, cp_start, cp_issue, vld_set, in_range;
	logic           done_d, starved_d;
	logic [15:0]    rdata_d, reg_old;

	// memory ports
	logic           reg_we, reg_re;
	logic [AW-1:0]  reg_waddr, reg_raddr;
	logic [15:0]    reg_wdata, reg_rdata;
	logic           rq_we, rq_re;
	logic [QAW-1:0] rq_waddr, rq_raddr;
	logic [7:0]     rq_wdata, rq_rdata;
	logic           rs_we, rs_re;
	logic [RAW-1:0] rs_waddr, rs_raddr;
	logic [7:0]     rs_wdata, rs_rdata;

	// register store
	plsp_ram #(.WIDTH(16), .DEPTH(REG_WORDS)) u_reg_ram (
		.clk     (clk),
		.wr_en   (reg_we),
		.wr_addr (reg_waddr),
		.wr_data (reg_wdata),
		.rd_en   (reg_re),
		.rd_addr (reg_raddr),
		.rd_data (reg_rdata)
	);

	// reply queue
	plsp_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_reply_ram (
		.clk     (clk),
		.wr_en   (rq_we),
		.wr_addr (rq_waddr),
		.wr_data (rq_wdata),
		.rd_en   (rq_re),
		.rd_addr (rq_raddr),
		.rd_data (rq_rdata)
	);

	// report store
	plsp_ram #(.WIDTH(8), .DEPTH(PL)) u_report_ram (
		.clk     (clk),
		.wr_en   (rs_we),
		.wr_addr (rs_waddr),
		.wr_data (rs_wdata),
		.rd_en   (rs_re),
		.rd_addr (rs_raddr),
		.rd_data (rs_rdata)
	);

	// word range check and stored value as the model sees it
	assign in_range = ({1'b0, word_q} < 11'(REG_WORDS));
	assign reg_old  = in_range ? reg_rdata : 16'h0000;
	assign tx_inc   = tx_q + CW'(1);

	// report byte from the walk, reset value where never loaded
	assign cp_byte  = rpt_vld_q[cp_idx_s1] ? rs_rdata
		: plsp_pkg::rpt_reset_byte(6'(cp_idx_s1));

	// end-around-carry checksum step
	assign acc_sum  = {1'b0, acc_q} + {1'b0, cp_byte};
	assign acc_next = acc_sum[7:0] + {7'b0, acc_sum[8]};

	// next state, memory accesses and result
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		tx_d      = tx_q;
		accept    = 1'b0;
		out_load  = 1'b0;
		cp_start  = 1'b0;
		cp_issue  = 1'b0;
		vld_set   = 1'b0;
		rdata_d   = 16'h0000;
		done_d    = 1'b0;
		starved_d = 1'b0;
		reg_we    = 1'b0;
		reg_waddr = word_q[AW-1:0];
		reg_wdata = wdata_q;
		reg_re    = 1'b0;
		reg_raddr = reg_word[AW-1:0];
		rq_we     = 1'b0;
		rq_waddr  = QAW'(cp_idx_s1);
		rq_wdata  = cp_byte;
		rq_re     = 1'b0;
		rq_raddr  = head_q;
		rs_we     = 1'b0;
		rs_waddr  = ridx_q[RAW-1:0];
		rs_wdata  = rbyte_q;
		rs_re     = 1'b0;
		rs_raddr  = cp_rd_q[RAW-1:0];
		case (state_q)
			plsp_pkg::ST_CLEAR: begin
				reg_we    = 1'b1;
				reg_waddr = clr_q;
				reg_wdata = (clr_q == AW'(plsp_pkg::W_STATUS)) ? plsp_pkg::ST_RESET : 16'h0000;
				if (clr_q == AW'(REG_WORDS - 1)) begin
					state_d = plsp_pkg::ST_IDLE;
				end
			end
			plsp_pkg::ST_IDLE: begin
				if (in_valid) begin
					accept  = 1'b1;
					reg_re  = 1'b1;
					rq_re   = 1'b1;
					state_d = plsp_pkg::ST_EXEC;
				end
			end
			plsp_pkg::ST_EXEC: begin
				if (!(out_valid_q && out_stall)) begin
					out_load = 1'b1;
					state_d  = plsp_pkg::ST_IDLE;
					case (op_q)
						plsp_pkg::OP_READ: begin
							if (word_q == plsp_pkg::W_RXDATA) begin
								if (count_q == '0) begin
									starved_d = 1'b1;
								end else begin
									rdata_d = {8'h00, rq_rdata};
									head_d  = head_q + QAW'(1);
									count_d = count_q - CW'(1);
								end
							end else if (word_q == plsp_pkg::W_STATUS) begin
								rdata_d = reg_old | ((count_q != '0) ? plsp_pkg::ST_RDF : 16'h0000);
							end else if (word_q == plsp_pkg::W_FILL) begin
								rdata_d = 16'(count_q) & plsp_pkg::FILL_MASK;
							end else begin
								rdata_d = reg_old;
							end
						end
						plsp_pkg::OP_WRITE: begin
							if (word_q == plsp_pkg::W_TXDATA) begin
								if (tx_inc >= CW'(FRAME_BYTES)) begin
									tx_d     = '0;
									done_d   = 1'b1;
									cp_start = 1'b1;
									state_d  = plsp_pkg::ST_COPY;
								end else begin
									tx_d = tx_inc;
								end
							end else if (word_q == plsp_pkg::W_STATUS) begin
								reg_we    = in_range;
								reg_wdata = (reg_old & (wdata_q | ~plsp_pkg::ST_HW))
									| plsp_pkg::ST_RESET;
							end else if (word_q == plsp_pkg::W_FIFOCTL) begin
								if ((wdata_q & plsp_pkg::FC_RXRST) != 16'h0000) begin
									count_d = '0;
									head_d  = '0;
								end
								if ((wdata_q & plsp_pkg::FC_TXRST) != 16'h0000) begin
									tx_d = '0;
								end
								reg_we = in_range;
							end else if (word_q == plsp_pkg::W_LINESTAT) begin
								reg_we    = in_range;
								reg_wdata = reg_old & wdata_q;
							end else begin
								reg_we = in_range;
							end
						end
						plsp_pkg::OP_LOAD: begin
							if ({1'b0, ridx_q} < 7'(PL)) begin
								rs_we   = 1'b1;
								vld_set = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			plsp_pkg::ST_COPY: begin
				// read one report byte a cycle, write the previous one to the queue
				cp_issue = (cp_rd_q < PW'(PL));
				rs_re    = cp_issue;
				if (cp_vld_s1) begin
					rq_we = 1'b1;
					if (cp_idx_s1 == RAW'(PL - 1)) begin
						state_d = plsp_pkg::ST_CSUM;
					end
				end
			end
			plsp_pkg::ST_CSUM: begin
				rq_we    = 1'b1;
				rq_waddr = QAW'(PL);
				rq_wdata = acc_q;
				state_d  = plsp_pkg::ST_SYNC;
			end
			plsp_pkg::ST_SYNC: begin
				rq_we    = 1'b1;
				rq_waddr = QAW'(FRAME_BYTES - 1);
				rq_wdata = plsp_pkg::SYNC_BYTE;
				head_d   = '0;
				count_d  = CW'(FRAME_BYTES);
				state_d  = plsp_pkg::ST_IDLE;
			end
			default: begin
				state_d = plsp_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= plsp_pkg::ST_CLEAR;
			clr_q     <= '0;
			head_q    <= '0;
			count_q   <= '0;
			tx_q      <= '0;
			rpt_vld_q <= '0;
			cp_rd_q   <= '0;
			cp_vld_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			tx_q    <= tx_d;
			if (state_q == plsp_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (vld_set) begin
				rpt_vld_q[ridx_q[RAW-1:0]] <= 1'b1;
			end
			if (cp_start) begin
				cp_rd_q <= '0;
			end else if (cp_issue) begin
				cp_rd_q <= cp_rd_q + PW'(1);
			end
			cp_vld_s1 <= cp_issue;
		end
	end

	// request capture and checksum accumulator
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= plsp_pkg::plsp_op_t'(op);
			word_q  <= reg_word;
			wdata_q <= wdata;
			ridx_q  <= report_index;
			rbyte_q <= report_byte;
		end
		cp_idx_s1 <= cp_rd_q[RAW-1:0];
		if (cp_start) begin
			acc_q <= 8'h00;
		end else if (cp_vld_s1) begin
			acc_q <= acc_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rdata_q   <= rdata_d;
			done_q    <= done_d;
			starved_q <= starved_d;
		end
	end

	assign in_stall   = (state_q != plsp_pkg::ST_IDLE);
	assign out_valid  = out_valid_q;
	assign rdata      = rdata_q;
	assign frame_done = done_q;
	assign starved    = starved_q;

	// checks
	`PLSP_NEVER(a_count_max, count_q > CW'(FRAME_BYTES), "reply count beyond frame length")
	`PLSP_NEVER(a_tx_max, tx_q >= CW'(FRAME_BYTES), "transmit count not wrapped at frame end")
	`PLSP_ASSERT(a_sync_fill, (state_q == plsp_pkg::ST_SYNC) |=> (count_q == CW'(FRAME_BYTES) && head_q == '0), "queue not refilled after sync byte")
	`PLSP_ASSERT(a_copy_stage, cp_vld_s1 |-> (state_q == plsp_pkg::ST_COPY), "copy stage active outside report walk")
	`PLSP_NEVER(a_out_flags, out_valid_q && done_q && starved_q, "frame done and starved on one result")

endmodule

// ----- design/plsp_ram.sv -----
// generic single write port, single read port ram with registered read
module plsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port, data holds between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- sim/panel_link_serial_port_top_tb.sv -----
// self-checking testbench for the panel link serial port register block
`timescale 1ns / 100ps

module panel_link_serial_port_top_tb;

	localparam int FRAME_LEN   = plsp_pkg::FRAME_BYTES_DEF;
	localparam int REPORT_LEN  = FRAME_LEN - 2;
	localparam int REG_COUNT   = plsp_pkg::REG_WORDS_DEF;
	localparam int REQ_TARGET  = 1650;
	localparam int SETTLE_CYC  = 100;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORTED    = 10;

	// spare op code with no function
	localparam logic [1:0] OP_NOP = 2'd3;

	typedef struct {
		logic [1:0]  op;
		logic [9:0]  word;
		logic [15:0] data;
		logic [5:0]  idx;
		logic [7:0]  rbyte;
		bit          drain;
	} serial_req_t;

	typedef struct {
		logic [15:0] rdata;
		logic        frame_done;
		logic        starved;
	} serial_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  op = 2'd0;
	logic [9:0]  reg_word = 10'd0;
	logic [15:0] wdata = 16'h0000;
	logic [5:0]  report_index = 6'd0;
	logic [7:0]  report_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] rdata;
	logic        frame_done;
	logic        starved;

	serial_req_t pending_req_q[$];
	serial_res_t expected_res_q[$];
	serial_req_t cur_req;
	serial_res_t cur_res;
	serial_res_t want_res;
	bit          slot_free;
	int          total_req = 1;
	int          directed_cnt;
	int          req_accepted;
	int          res_checked;
	int          mismatch_cnt;
	int          cycle_cnt;

	// shadow state of the block
	logic [15:0] shadow_regs[REG_COUNT];
	logic [7:0]  shadow_reply[FRAME_LEN];
	logic [7:0]  shadow_report[REPORT_LEN];
	int          shadow_head;
	int          shadow_fill;
	int          shadow_tx;

	panel_link_serial_port_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.reg_word(reg_word),
		.wdata(wdata),
		.report_index(report_index),
		.report_byte(report_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.rdata(rdata),
		.frame_done(frame_done),
		.starved(starved)
	);

	// clock and reset
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// end-around-carry sum over the report bytes
	function automatic logic [7:0] report_checksum();
		logic [8:0] acc;
		acc = 9'd0;
		for (int i = 0; i < REPORT_LEN; i++) begin
			acc = acc + {1'b0, shadow_report[i]};
			if (acc[8]) begin
				acc = {1'b0, acc[7:0]} + 9'd1;
			end
		end
		return acc[7:0];
	endfunction

	function automatic void shadow_reset();
		for (int i = 0; i < REG_COUNT; i++) begin
			shadow_regs[i] = 16'h0000;
		end
		shadow_regs[plsp_pkg::W_STATUS] = plsp_pkg::ST_TEND | plsp_pkg::ST_TDFE;
		for (int i = 0; i < REPORT_LEN; i++) begin
			shadow_report[i] = 8'h00;
		end
		shadow_report[4] = 8'h80;
		shadow_report[6] = 8'h80;
		shadow_head = 0;
		shadow_fill = 0;
		shadow_tx = 0;
	endfunction

	// expected result of one request, updating the shadow state
	function automatic serial_res_t serial_port_step(serial_req_t rq);
		serial_res_t res;
		res.rdata = 16'h0000;
		res.frame_done = 1'b0;
		res.starved = 1'b0;
		case (rq.op)
		plsp_pkg::OP_READ: begin
			if (rq.word == plsp_pkg::W_RXDATA) begin
				if (shadow_fill == 0) begin
					res.starved = 1'b1;
				end else begin
					res.rdata = {8'h00, shadow_reply[shadow_head]};
					shadow_head++;
					shadow_fill--;
				end
			end else if (rq.word == plsp_pkg::W_STATUS) begin
				res.rdata = shadow_regs[plsp_pkg::W_STATUS]
					| ((shadow_fill != 0) ? plsp_pkg::ST_RDF : 16'h0000);
			end else if (rq.word == plsp_pkg::W_FILL) begin
				res.rdata = 16'(shadow_fill) & plsp_pkg::FILL_MASK;
			end else begin
				res.rdata = shadow_regs[rq.word];
			end
		end
		plsp_pkg::OP_WRITE: begin
			if (rq.word == plsp_pkg::W_TXDATA) begin
				shadow_tx++;
				if (shadow_tx >= FRAME_LEN) begin
					shadow_tx = 0;
					for (int i = 0; i < REPORT_LEN; i++) begin
						shadow_reply[i] = shadow_report[i];
					end
					shadow_reply[REPORT_LEN] = report_checksum();
					shadow_reply[REPORT_LEN + 1] = plsp_pkg::SYNC_BYTE;
					shadow_head = 0;
					shadow_fill = FRAME_LEN;
					res.frame_done = 1'b1;
				end
			end else if (rq.word == plsp_pkg::W_STATUS) begin
				shadow_regs[plsp_pkg::W_STATUS] = (shadow_regs[plsp_pkg::W_STATUS]
					& (rq.data | ~plsp_pkg::ST_HW)) | plsp_pkg::ST_TEND | plsp_pkg::ST_TDFE;
			end else if (rq.word == plsp_pkg::W_FIFOCTL) begin
				if ((rq.data & plsp_pkg::FC_RXRST) != 16'h0000) begin
					shadow_fill = 0;
					shadow_head = 0;
				end
				if ((rq.data & plsp_pkg::FC_TXRST) != 16'h0000) begin
					shadow_tx = 0;
				end
				shadow_regs[plsp_pkg::W_FIFOCTL] = rq.data;
			end else if (rq.word == plsp_pkg::W_LINESTAT) begin
				shadow_regs[plsp_pkg::W_LINESTAT] = shadow_regs[plsp_pkg::W_LINESTAT] & rq.data;
			end else begin
				shadow_regs[rq.word] = rq.data;
			end
		end
		plsp_pkg::OP_LOAD: begin
			if (rq.idx < REPORT_LEN) begin
				shadow_report[rq.idx] = rq.rbyte;
			end
		end
		default: begin
		end
		endcase
		return res;
	endfunction

	// idle percentage of the current phase
	function automatic int idle_pct(bit sender);
		int ph;
		ph = (req_accepted * 4) / total_req;
		if (ph > 3) begin
			ph = 3;
		end
		case (ph)
		0: return 0;
		1: return sender ? 51 : 0;
		2: return sender ? 0 : 51;
		default: return 22;
		endcase
	endfunction

	// stimulus building
	task automatic queue_request(logic [1:0] o, logic [9:0] w, logic [15:0] d,
			logic [5:0] i, logic [7:0] b);
		serial_req_t rq;
		rq.op = o;
		rq.word = w;
		rq.data = d;
		rq.idx = i;
		rq.rbyte = b;
		rq.drain = 1'b0;
		pending_req_q.push_back(rq);
	endtask

	task automatic queue_rand(logic [1:0] o, logic [9:0] w);
		queue_request(o, w, 16'($urandom), 6'($urandom), 8'($urandom));
	endtask

	task automatic queue_noise();
		case ($urandom_range(9, 0))
		0: queue_rand(plsp_pkg::OP_READ, plsp_pkg::W_STATUS);
		1: queue_rand(plsp_pkg::OP_WRITE, plsp_pkg::W_STATUS);
		2: queue_rand(plsp_pkg::OP_READ, plsp_pkg::W_FILL);
		3: queue_rand(plsp_pkg::OP_READ, 10'($urandom));
		4: queue_rand(plsp_pkg::OP_WRITE, 10'($urandom));
		5: queue_rand(OP_NOP, 10'($urandom));
		6: queue_rand(plsp_pkg::OP_WRITE, plsp_pkg::W_LINESTAT);
		7: queue_rand(plsp_pkg::OP_LOAD, 10'($urandom));
		8: queue_rand(plsp_pkg::OP_WRITE, plsp_pkg::W_FIFOCTL);
		default: queue_rand(plsp_pkg::OP_READ, plsp_pkg::W_TXDATA);
		endcase
	endtask

	// report loads, a full frame of transmit bytes, then receive reads
	task automatic queue_frame_round();
		int n;
		n = $urandom_range(12, 0);
		repeat (n) begin
			queue_request(plsp_pkg::OP_LOAD, 10'($urandom), 16'($urandom),
				6'($urandom_range(REPORT_LEN - 1, 0)), 8'($urandom));
		end
		for (int i = 0; i < FRAME_LEN; i++) begin
			if ($urandom_range(9, 0) == 0) begin
				queue_noise();
			end
			queue_rand(plsp_pkg::OP_WRITE, plsp_pkg::W_TXDATA);
		end
		n = $urandom_range(FRAME_LEN + 8, 0);
		repeat (n) begin
			if ($urandom_range(11, 0) == 0) begin
				queue_noise();
			end
			queue_rand(plsp_pkg::OP_READ, plsp_pkg::W_RXDATA);
		end
	endtask

	initial begin
		shadow_reset();

		// directed requests
		queue_request(plsp_pkg::OP_READ, plsp_pkg::W_STATUS, 16'h0000, 6'd0, 8'h00);
		queue_request(plsp_pkg::OP_READ, plsp_pkg::W_FILL, 16'hFFFF, 6'd63, 8'hFF);
		queue_request(plsp_pkg::OP_READ, plsp_pkg::W_RXDATA, 16'h0000, 6'd0, 8'h00);
		queue_request(plsp_pkg::OP_WRITE, plsp_pkg::W_STATUS, 16'h0000, 6'd0, 8'h00);
		queue_request(plsp_pkg::OP_READ, plsp_pkg::W_STATUS, 16'h0000, 6'd0, 8'h00);
		queue_request(plsp_pkg::OP_WRITE, plsp_pkg::W_STATUS, 16'hFFFF, 6'd63, 8'hFF);
		queue_request(plsp_pkg::OP_READ, plsp_pkg::W_STATUS, 16'h0000, 6'd0, 8'h00);
		queue_request(plsp_pkg::OP_LOAD, 10'd0, 16'h0000, 6'd0, 8'hFF);
		queue_request(plsp_pkg::OP_LOAD, 10'h3FF, 16'hFFFF, 6'(REPORT_LEN - 1), 8'h00);
		queue_request(plsp_pkg::OP_LOAD, 10'd0, 16'h0000, 6'(REPORT_LEN), 8'hFF);
		queue_request(plsp_pkg::OP_LOAD, 10'h3FF, 16'hFFFF, 6'd63, 8'hFF);
		queue_request(OP_NOP, 10'h3FF, 16'hFFFF, 6'd63, 8'hFF);
		queue_request(plsp_pkg::OP_WRITE, plsp_pkg::W_LINESTAT, 16'hFFFF, 6'd0, 8'h00);
		queue_request(plsp_pkg::OP_READ, plsp_pkg::W_LINESTAT, 16'h0000, 6'd0, 8'h00);
		queue_request(plsp_pkg::OP_WRITE, 10'h3FF, 16'hFFFF, 6'd0, 8'h00);
		queue_request(plsp_pkg::OP_READ, 10'h3FF, 16'h0000, 6'd0, 8'h00);
		queue_request(plsp_pkg::OP_WRITE, 10'd0, 16'hFFFF, 6'd0, 8'h00);
		queue_request(plsp_pkg::OP_READ, 10'd0, 16'h0000, 6'd0, 8'h00);
		queue_request(plsp_pkg::OP_WRITE, plsp_pkg::W_TXDATA, 16'hFFFF, 6'd0, 8'h00);
		queue_request(plsp_pkg::OP_READ, plsp_pkg::W_TXDATA, 16'h0000, 6'd0, 8'h00);
		queue_request(plsp_pkg::OP_WRITE, plsp_pkg::W_FIFOCTL, 16'h0006, 6'd0, 8'h00);
		queue_request(plsp_pkg::OP_READ, plsp_pkg::W_FIFOCTL, 16'h0000, 6'd0, 8'h00);
		queue_request(plsp_pkg::OP_WRITE, plsp_pkg::W_FILL, 16'hABCD, 6'd0, 8'h00);
		queue_request(plsp_pkg::OP_READ, plsp_pkg::W_FILL, 16'h0000, 6'd0, 8'h00);
		queue_request(plsp_pkg::OP_WRITE, plsp_pkg::W_RXDATA, 16'h1234, 6'd0, 8'h00);
		directed_cnt = pending_req_q.size();

		// random part, mostly whole frames
		while (pending_req_q.size() < directed_cnt + REQ_TARGET) begin
			if ($urandom_range(4, 0) == 0) begin
				repeat (8) queue_noise();
			end else begin
				queue_frame_round();
			end
		end
		total_req = pending_req_q.size();

		// sender waits for the block to drain at these points
		pending_req_q[directed_cnt].drain = 1'b1;
		for (int k = 1; k < 4; k++) begin
			pending_req_q[(total_req * k) / 4].drain = 1'b1;
		end
		pending_req_q[$urandom_range(total_req - 1, directed_cnt)].drain = 1'b1;

		// wait for every request and result, then settle
		while (pending_req_q.size() != 0 || in_valid || expected_res_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYC) @(posedge clk);
		if (mismatch_cnt == 0 && expected_res_q.size() == 0) begin
			$display("PASS panel_link_serial_port_top");
		end else begin
			$display("FAIL panel_link_serial_port_top");
		end
		$finish;
	end

	// run limit
	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("FAIL panel_link_serial_port_top");
		$finish;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			slot_free = !in_valid;
			if (in_valid && !in_stall) begin
				cur_res = serial_port_step(cur_req);
				expected_res_q.push_back(cur_res);
				req_accepted++;
				slot_free = 1'b1;
			end
			if (slot_free) begin
				if (pending_req_q.size() != 0
						&& !(pending_req_q[0].drain && expected_res_q.size() != 0)
						&& $urandom_range(99, 0) >= idle_pct(1'b1)) begin
					cur_req = pending_req_q.pop_front();
					op <= cur_req.op;
					reg_word <= cur_req.word;
					wdata <= cur_req.data;
					report_index <= cur_req.idx;
					report_byte <= cur_req.rbyte;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_res_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= REPORTED) begin
						$display("unexpected result: rdata %h frame_done %b starved %b",
							rdata, frame_done, starved);
					end
				end else begin
					want_res = expected_res_q.pop_front();
					if (rdata !== want_res.rdata || frame_done !== want_res.frame_done
							|| starved !== want_res.starved) begin
						mismatch_cnt++;
						if (mismatch_cnt <= REPORTED) begin
							$display("result %0d mismatch: expected rdata %h frame_done %b starved %b",
								res_checked, want_res.rdata, want_res.frame_done,
								want_res.starved);
							$display("  got rdata %h frame_done %b starved %b",
								rdata, frame_done, starved);
						end
					end
				end
				res_checked++;
			end
			out_stall <= ($urandom_range(99, 0) < idle_pct(1'b0));
		end
	end

endmodule

// ----- files.f -----
+incdir+design
design/plsp_pkg.sv
design/plsp_ram.sv
design/panel_link_serial_port_top.sv
sim/panel_link_serial_port_top_tb.sv
